// ===== design/per_client_gain_scaler_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the per-client gain scaler
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef PER_CLIENT_GAIN_SCALER_ASSERT_SVH
`define PER_CLIENT_GAIN_SCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCGS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pcgs: property failed");
`define PCGS_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("pcgs: implication failed");
`else
`define PCGS_ASSERT(label, prop)
`define PCGS_ASSERT_IMPLY(label, pre, post)
`endif
`endif

// ===== design/pcgs_pkg.sv =====
// -----------------------------------------------------------------------------
// pcgs_pkg
// Sizes, codes and types shared by the per-client gain scaler modules.
// -----------------------------------------------------------------------------
package pcgs_pkg;

    localparam int CLIENT_SLOTS  = 2048;
    localparam int TABLE_ENTRIES = 512;
    localparam int QUEUE_DEPTH   = 2;

    localparam int MODE_W    = 2;
    localparam int CLIENT_W  = 32;
    localparam int PID_W     = 31;
    localparam int GAIN_W    = 16;
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_FRAC = 15;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;

    localparam int SLOT_W = $clog2(CLIENT_SLOTS);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(32768);

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_FRAME    = 2'd0,
        MODE_SET_GAIN = 2'd1,
        MODE_BIND     = 2'd2,
        MODE_UNBIND   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MAP,
        BK_SEARCH,
        BK_MUL,
        BK_EMIT
    } t_back_state;

    // A request after classification, as it waits in the queue.
    typedef struct packed {
        t_mode                mode;
        logic                 slot_ok;
        logic [SLOT_W-1:0]    slot;
        logic [PID_W-1:0]     pid;
        logic [GAIN_W-1:0]    gain;
        logic                 mute;
        logic [SAMPLE_W-1:0]  left;
        logic [SAMPLE_W-1:0]  right;
        logic                 frame_last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_entry;

    typedef struct packed {
        logic                status;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic [GAIN_W-1:0]   gain;
        logic                frame_last;
    } t_result;

endpackage

// ===== design/pcgs_in_if.sv =====
// -----------------------------------------------------------------------------
// pcgs_in_if
// Request channel of the gain scaler: valid, ready and the request fields.
// -----------------------------------------------------------------------------
interface pcgs_in_if import pcgs_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [CLIENT_W-1:0] client_id;
    logic [PID_W-1:0]    pid;
    logic [GAIN_W-1:0]   gain;
    logic                mute;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                frame_last;

    modport source (
        output valid, mode, client_id, pid, gain, mute, left_in, right_in, frame_last,
        input  ready
    );

    modport sink (
        input  valid, mode, client_id, pid, gain, mute, left_in, right_in, frame_last,
        output ready
    );

endinterface

// ===== design/pcgs_out_if.sv =====
// -----------------------------------------------------------------------------
// pcgs_out_if
// Result channel of the gain scaler: valid, ready and the result fields.
// -----------------------------------------------------------------------------
interface pcgs_out_if import pcgs_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       status;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic [GAIN_W-1:0]          gain_applied;
    logic                       frame_last_out;

    modport source (
        output valid, status, left_out, right_out, gain_applied, frame_last_out,
        input  ready
    );

    modport sink (
        input  valid, status, left_out, right_out, gain_applied, frame_last_out,
        output ready
    );

endinterface

// ===== design/pcgs_front.sv =====
// -----------------------------------------------------------------------------
// pcgs_front
// Accepts requests, checks the client slot range, saturates the gain and
// holds the classified request in a register until the queue takes it.
// -----------------------------------------------------------------------------
module pcgs_front import pcgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcgs_in_if.sink    i_in,
    input  logic       i_q_room,
    input  logic       i_hold,
    output t_q_entry   o_push
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    // Nothing is taken while the back end is still clearing the client map.
    assign i_in.ready = (!r_valid || i_q_room) && !i_hold;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_cmd            = r_cmd;
        n_cmd.mode       = t_mode'(i_in.mode);
        n_cmd.slot_ok    = i_in.client_id < CLIENT_W'(CLIENT_SLOTS);
        n_cmd.slot       = i_in.client_id[SLOT_W-1:0];
        n_cmd.pid        = i_in.pid;
        n_cmd.gain       = (i_in.gain > UNITY_GAIN) ? UNITY_GAIN : i_in.gain;
        n_cmd.mute       = i_in.mute;
        n_cmd.left       = i_in.left_in;
        n_cmd.right      = i_in.right_in;
        n_cmd.frame_last = i_in.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_q_room) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.cmd   = r_cmd;

endmodule

// ===== design/pcgs_queue.sv =====
// -----------------------------------------------------------------------------
// pcgs_queue
// Short request queue between the front end and the back end.
// -----------------------------------------------------------------------------
`include "per_client_gain_scaler_assert.svh"

module pcgs_queue import pcgs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_entry  i_push,
    input  logic      i_pop,
    output logic      o_room,
    output t_q_entry  o_head
);

    t_cmd              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic              push_en;
    logic              pop_en;

    assign o_room       = r_fill < QCNT_W'(QUEUE_DEPTH);
    assign push_en      = i_push.valid && o_room;
    assign pop_en       = i_pop && (r_fill != '0);
    assign o_head.valid = r_fill != '0;
    assign o_head.cmd   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop_en && !push_en) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_slots[r_wr_ptr] <= i_push.cmd;
        end
    end

    // The back end must only take a request that is really there.
    `PCGS_ASSERT_IMPLY(a_q_pop_nonempty, i_pop, r_fill != '0)

endmodule

// ===== design/pcgs_back.sv =====
// -----------------------------------------------------------------------------
// pcgs_back
// Executes queued requests: client map access, linear gain table search,
// table update, sample scaling and the output register.
// -----------------------------------------------------------------------------
`include "per_client_gain_scaler_assert.svh"

module pcgs_back import pcgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_entry    i_head,
    output logic        o_pop,
    output logic        o_clearing,
    pcgs_out_if.source  o_out
);

    // Client map and gain table memories.
    logic [PID_W-1:0]  r_map_mem      [CLIENT_SLOTS];
    logic [PID_W-1:0]  r_tbl_pid_mem  [TABLE_ENTRIES];
    logic [GAIN_W-1:0] r_tbl_gain_mem [TABLE_ENTRIES];
    logic              r_tbl_mute_mem [TABLE_ENTRIES];
    logic [PID_W-1:0]  r_map_q;
    logic [PID_W-1:0]  r_tbl_pid_q;
    logic [GAIN_W-1:0] r_tbl_gain_q;
    logic              r_tbl_mute_q;

    t_back_state       r_state,   n_state;
    t_cmd              r_cmd,     n_cmd;
    logic [PID_W-1:0]  r_key,     n_key;
    logic [CNT_W-1:0]  r_idx,     n_idx;
    logic              r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]  r_rd_idx,  n_rd_idx;
    logic [GAIN_W-1:0] r_gain,    n_gain;
    logic              r_status,  n_status;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic [SLOT_W-1:0] r_clr_idx, n_clr_idx;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    logic              r_out_valid;
    t_result           r_out,     n_out;

    logic              map_we;
    logic [SLOT_W-1:0] map_waddr;
    logic [PID_W-1:0]  map_wdata;
    logic              map_re;
    logic              tbl_re;
    logic [IDX_W-1:0]  tbl_raddr;
    logic              tbl_we_pid;
    logic              tbl_we_gm;
    logic [IDX_W-1:0]  tbl_waddr;
    logic              tbl_full;
    logic              hit;
    logic              emit_load;

    assign tbl_full = r_count == CNT_W'(TABLE_ENTRIES);
    assign hit = (r_state == BK_SEARCH) && r_rd_pend && (r_tbl_pid_q == r_key);
    assign emit_load = (r_state == BK_EMIT) && (!r_out_valid || o_out.ready);
    assign o_clearing = r_state == BK_CLEAR;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_idx      = r_idx;
        n_rd_pend  = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_gain     = r_gain;
        n_status   = r_status;
        n_count    = r_count;
        n_clr_idx  = r_clr_idx;
        map_we     = 1'b0;
        map_waddr  = r_clr_idx;
        map_wdata  = '0;
        map_re     = 1'b0;
        tbl_re     = 1'b0;
        tbl_raddr  = r_idx[IDX_W-1:0];
        tbl_we_pid = 1'b0;
        tbl_we_gm  = 1'b0;
        tbl_waddr  = r_rd_idx;
        o_pop      = 1'b0;

        case (r_state)
            BK_CLEAR: begin
                map_we = 1'b1;
                if (r_clr_idx == SLOT_W'(CLIENT_SLOTS - 1)) begin
                    n_state = BK_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_head.cmd;
                    n_status = STATUS_DONE;
                    n_idx    = '0;
                    case (i_head.cmd.mode)
                        MODE_FRAME: begin
                            map_re  = 1'b1;
                            n_state = BK_MAP;
                        end
                        MODE_SET_GAIN: begin
                            n_key   = i_head.cmd.pid;
                            n_state = BK_SEARCH;
                        end
                        default: begin
                            // Bind and unbind touch only the client map.
                            map_we    = i_head.cmd.slot_ok;
                            map_waddr = i_head.cmd.slot;
                            map_wdata = (i_head.cmd.mode == MODE_BIND) ? i_head.cmd.pid : '0;
                            n_state   = BK_EMIT;
                        end
                    endcase
                end
            end
            BK_MAP: begin
                n_key   = r_cmd.slot_ok ? r_map_q : '0;
                n_state = BK_SEARCH;
            end
            BK_SEARCH: begin
                // One entry is read per cycle; its compare happens the cycle after.
                if (hit) begin
                    if (r_cmd.mode == MODE_FRAME) begin
                        n_gain  = r_tbl_mute_q ? '0 : r_tbl_gain_q;
                        n_state = BK_MUL;
                    end else begin
                        tbl_we_gm = 1'b1;
                        tbl_waddr = r_rd_idx;
                        n_state   = BK_EMIT;
                    end
                end else if (r_idx < r_count) begin
                    tbl_re    = 1'b1;
                    n_rd_idx  = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_rd_pend = 1'b1;
                end else if (!r_rd_pend) begin
                    if (r_cmd.mode == MODE_FRAME) begin
                        n_gain  = UNITY_GAIN;
                        n_state = BK_MUL;
                    end else begin
                        if (!tbl_full) begin
                            tbl_we_pid = 1'b1;
                            tbl_we_gm  = 1'b1;
                            tbl_waddr  = r_count[IDX_W-1:0];
                            n_count    = r_count + 1'b1;
                        end else begin
                            n_status = STATUS_FULL;
                        end
                        n_state = BK_EMIT;
                    end
                end
            end
            BK_MUL: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (emit_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out.status = r_status;
        if (r_cmd.mode == MODE_FRAME) begin
            n_out.left       = r_prod_l[GAIN_FRAC +: SAMPLE_W];
            n_out.right      = r_prod_r[GAIN_FRAC +: SAMPLE_W];
            n_out.gain       = r_gain;
            n_out.frame_last = r_cmd.frame_last;
        end else begin
            n_out.left       = '0;
            n_out.right      = '0;
            n_out.gain       = '0;
            n_out.frame_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_clr_idx <= n_clr_idx;
            r_rd_pend <= n_rd_pend;
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_gain   <= n_gain;
        r_status <= n_status;
        if (r_state == BK_MUL) begin
            r_prod_l <= PROD_W'($signed(r_cmd.left)) * PROD_W'($signed({1'b0, r_gain}));
            r_prod_r <= PROD_W'($signed(r_cmd.right)) * PROD_W'($signed({1'b0, r_gain}));
        end
        if (emit_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            r_map_q <= r_map_mem[i_head.cmd.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we_pid) begin
            r_tbl_pid_mem[tbl_waddr] <= r_cmd.pid;
        end
        if (tbl_we_gm) begin
            r_tbl_gain_mem[tbl_waddr] <= r_cmd.gain;
            r_tbl_mute_mem[tbl_waddr] <= r_cmd.mute;
        end
        if (tbl_re) begin
            r_tbl_pid_q  <= r_tbl_pid_mem[tbl_raddr];
            r_tbl_gain_q <= r_tbl_gain_mem[tbl_raddr];
            r_tbl_mute_q <= r_tbl_mute_mem[tbl_raddr];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.left_out       = r_out.left;
    assign o_out.right_out      = r_out.right;
    assign o_out.gain_applied   = r_out.gain;
    assign o_out.frame_last_out = r_out.frame_last;

    `PCGS_ASSERT_IMPLY(a_no_pop_while_clear, r_state == BK_CLEAR, !o_pop)
    `PCGS_ASSERT_IMPLY(a_full_only_when_full, emit_load && (r_status == STATUS_FULL), tbl_full)
    `PCGS_ASSERT_IMPLY(a_hit_below_count, hit, CNT_W'(r_rd_idx) < r_count)

endmodule

// ===== design/per_client_gain_scaler.sv =====
// -----------------------------------------------------------------------------
// per_client_gain_scaler
// Per-client stereo gain stage with a client map and a bounded gain table.
// -----------------------------------------------------------------------------
// After reset the block zeroes the client map, one slot a cycle, and accepts
// no request until that pass is done. Requests then run one at a time in the
// back end, while the front register and a two-entry queue keep taking new
// ones. The table is searched one entry per cycle through its single read
// port, over the gain table entries in use (up to 512). A finished result
// waits in the output register; the next request may start, but its own
// result is held until the waiting one is taken.
module per_client_gain_scaler import pcgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcgs_in_if.sink     i_in,
    pcgs_out_if.source  o_out
);

    t_q_entry push;
    t_q_entry head;
    logic     q_room;
    logic     pop;
    logic     clearing;

    pcgs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_room (q_room),
        .i_hold   (clearing),
        .o_push   (push)
    );

    pcgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (q_room),
        .o_head  (head)
    );

    pcgs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule
